// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checking code of the odometry block.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/ddo_pkg.sv -----
// Package of the differential-drive odometry block: widths, register codes,
// datapath commands and the CORDIC arctangent table. Depends on nothing.
`timescale 1ns / 1ps
package ddo_pkg;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN = 2'd2;
   localparam logic [31:0] CSR_RESET_VAL = 32'd65536;
   // CORDIC start vector, gain-compensated, Q4.30
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_DIST_A, OP_DIST_B, OP_PREP, OP_ROT, OP_FIX,
      OP_X_LO, OP_X_HI, OP_X_ADD, OP_Y_LO, OP_Y_HI, OP_Y_ADD,
      OP_H_LO, OP_H_HI, OP_H_ADD
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load_out;
   } cmd_type;

   typedef struct packed {
      logic rot_last;
   } status_type;

   function automatic logic [31:0] atan_lookup(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
         5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
         5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
         5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
         5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction
endpackage

// ----- rtl/ddo_if.sv -----
// Channel interfaces of the odometry block: sample, pose and register write.
// Depends on ddo_pkg for the register index width.
`timescale 1ns / 1ps
interface ddo_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] enc_count_a;
   logic [31:0] enc_count_b;
   modport source (output valid, output enc_count_a, output enc_count_b, input ready);
   modport sink (input valid, input enc_count_a, input enc_count_b, output ready);
endinterface

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_y;
   logic [31:0]        pose_heading;
   modport source (output valid, output pose_x, output pose_y, output pose_heading,
                   input ready);
   modport sink (input valid, input pose_x, input pose_y, input pose_heading,
                 output ready);
endinterface

interface ddo_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ddo_pkg::CSR_IDX_W-1:0]  index;
   logic [31:0]                    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/differential_drive_odometry.sv -----
// Top level of the differential-drive odometry block: channel ports,
// sequencer and datapath. Depends on ddo_pkg, ddo_if, ddo_ctrl, ddo_datapath, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// req_bus carries one sampling tick: the two absolute encoder counts.
// rsp_bus returns one pose beat per tick: X, Y (signed, saturating) and
// heading (binary angle). csr_bus writes the left and right distance per
// tick and the turn per distance; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// After acceptance the block works out the two wheel distances, runs the
// CORDIC rotator, which runs one step a cycle, and updates X, Y and heading;
// the single shared 33x33 multiplier is used eight times per tick. Then the
// result beat is presented. A new tick is taken once the previous one has
// reached the output register.
// Reset clears the previous counts and the pose, loads 65536 into the three
// registers and drops any pending result beat.
// A stalled receiver holds the result beat in the output register; the next
// tick is still accepted and computed, and waits before its own result.
module differential_drive_odometry #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   ddo_req_if.sink   req_bus,
   ddo_rsp_if.source rsp_bus,
   ddo_csr_if.sink   csr_bus
);
   ddo_pkg::cmd_type    cmd;
   ddo_pkg::status_type status;

   assign csr_bus.ready = 1'b1;

   ddo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ddo_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .enc_count_a  (req_bus.enc_count_a),
      .enc_count_b  (req_bus.enc_count_b),
      .csr_write    (csr_bus.valid && csr_bus.ready),
      .csr_index    (csr_bus.index),
      .csr_data     (csr_bus.data),
      .pose_x       (rsp_bus.pose_x),
      .pose_y       (rsp_bus.pose_y),
      .pose_heading (rsp_bus.pose_heading)
   );

   // A taken tick makes the block busy in the next cycle
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready, "input taken while busy")
   // A result beat appears only at the end of a tick's work
   `ASSERT_IMPLY(a_rsp_from_work, clock, reset, $rose(rsp_bus.valid), $past(!req_bus.ready), "result beat without work")
   // The datapath is loaded only from the idle state
   `ASSERT_IMPLY(a_load_idle, clock, reset, cmd.op == ddo_pkg::OP_LOAD, req_bus.ready && req_bus.valid, "load outside acceptance")
endmodule

// ----- rtl/ddo_ctrl.sv -----
// Sequencer of the odometry block: steps the datapath through one sample.
// Depends on ddo_pkg for command and status types.
`timescale 1ns / 1ps
module ddo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ddo_pkg::status_type status,
   output ddo_pkg::cmd_type    cmd
);
   typedef enum logic [15:0] {
      ST_IDLE = 16'h0001, ST_DA = 16'h0002, ST_DB = 16'h0004, ST_PREP = 16'h0008,
      ST_ROT = 16'h0010, ST_FIX = 16'h0020, ST_XLO = 16'h0040, ST_XHI = 16'h0080,
      ST_XADD = 16'h0100, ST_YLO = 16'h0200, ST_YHI = 16'h0400, ST_YADD = 16'h0800,
      ST_HLO = 16'h1000, ST_HHI = 16'h2000, ST_HADD = 16'h4000, ST_OUT = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Pick the command and the next state
   always_comb begin
      state_in     = state_ff;
      cmd.op       = ddo_pkg::OP_NONE;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = ddo_pkg::OP_LOAD;
               state_in = ST_DA;
            end
         end
         ST_DA:   begin cmd.op = ddo_pkg::OP_DIST_A; state_in = ST_DB;   end
         ST_DB:   begin cmd.op = ddo_pkg::OP_DIST_B; state_in = ST_PREP; end
         ST_PREP: begin cmd.op = ddo_pkg::OP_PREP;   state_in = ST_ROT;  end
         ST_ROT: begin
            cmd.op = ddo_pkg::OP_ROT;
            if (status.rot_last) state_in = ST_FIX;
         end
         ST_FIX:  begin cmd.op = ddo_pkg::OP_FIX;   state_in = ST_XLO;  end
         ST_XLO:  begin cmd.op = ddo_pkg::OP_X_LO;  state_in = ST_XHI;  end
         ST_XHI:  begin cmd.op = ddo_pkg::OP_X_HI;  state_in = ST_XADD; end
         ST_XADD: begin cmd.op = ddo_pkg::OP_X_ADD; state_in = ST_YLO;  end
         ST_YLO:  begin cmd.op = ddo_pkg::OP_Y_LO;  state_in = ST_YHI;  end
         ST_YHI:  begin cmd.op = ddo_pkg::OP_Y_HI;  state_in = ST_YADD; end
         ST_YADD: begin cmd.op = ddo_pkg::OP_Y_ADD; state_in = ST_HLO;  end
         ST_HLO:  begin cmd.op = ddo_pkg::OP_H_LO;  state_in = ST_HHI;  end
         ST_HHI:  begin cmd.op = ddo_pkg::OP_H_HI;  state_in = ST_HADD; end
         ST_HADD: begin cmd.op = ddo_pkg::OP_H_ADD; state_in = ST_OUT;  end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result beat until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ----- rtl/ddo_datapath.sv -----
// Datapath of the odometry block: registers, shared 33x33 multiplier,
// CORDIC rotator and pose accumulators. Depends on ddo_pkg.
`timescale 1ns / 1ps
module ddo_datapath #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ddo_pkg::cmd_type              cmd,
   output ddo_pkg::status_type           status,
   input  logic [31:0]                   enc_count_a,
   input  logic [31:0]                   enc_count_b,
   input  logic                          csr_write,
   input  logic [ddo_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   output logic signed [31:0]            pose_x,
   output logic signed [31:0]            pose_y,
   output logic [31:0]                   pose_heading
);
   localparam logic [4:0] STEP_LAST = 5'(CORDIC_STEPS - 1);

   logic [31:0] left_ff, right_ff, turn_ff;
   logic [31:0] last_a_ff, last_b_ff, tick_a_ff, tick_b_ff;
   logic signed [31:0] x_ff, y_ff;
   logic [31:0] h_ff;
   logic signed [63:0] da_ff, centre_ff, diff_ff;
   logic signed [95:0] acc_ff, acc_in;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic        flip_ff;
   logic [4:0]  step_ff;
   logic signed [32:0] cos_ff, sin_ff;
   logic signed [31:0] out_x_ff, out_y_ff;
   logic [31:0] out_h_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic signed [95:0] prod_ext;
   logic signed [63:0] db_sat, da_sat_acc;
   logic signed [64:0] sum_ab;
   logic signed [63:0] step_d;
   logic signed [64:0] pos_sum;
   logic signed [31:0] pos_old, pos_new;
   logic [31:0] ang;
   logic        flip;
   logic signed [33:0] x_sh, y_sh, atan_ext;

   // Clamp a wheel distance to the 63-bit range
   function automatic logic signed [63:0] sat62(input logic signed [95:0] v);
      logic signed [63:0] r;
      if (!v[95] && (v[94:62] != '0))   r = 64'sh3FFF_FFFF_FFFF_FFFF;
      else if (v[95] && (v[94:62] != '1)) r = -64'sh4000_0000_0000_0000;
      else r = v[63:0];
      return r;
   endfunction

   assign status.rot_last = (step_ff == STEP_LAST);

   // Select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         ddo_pkg::OP_DIST_A: begin
            mul_a = {tick_a_ff[31], tick_a_ff}; mul_b = {1'b0, left_ff};
         end
         ddo_pkg::OP_DIST_B: begin
            mul_a = {tick_b_ff[31], tick_b_ff}; mul_b = {1'b0, right_ff};
         end
         ddo_pkg::OP_X_LO: begin mul_a = {1'b0, centre_ff[31:0]}; mul_b = cos_ff; end
         ddo_pkg::OP_X_HI: begin
            mul_a = {centre_ff[63], centre_ff[63:32]}; mul_b = cos_ff;
         end
         ddo_pkg::OP_Y_LO: begin mul_a = {1'b0, centre_ff[31:0]}; mul_b = sin_ff; end
         ddo_pkg::OP_Y_HI: begin
            mul_a = {centre_ff[63], centre_ff[63:32]}; mul_b = sin_ff;
         end
         ddo_pkg::OP_H_LO: begin mul_a = {1'b0, diff_ff[31:0]}; mul_b = {1'b0, turn_ff}; end
         ddo_pkg::OP_H_HI: begin
            mul_a = {diff_ff[63], diff_ff[63:32]}; mul_b = {1'b0, turn_ff};
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod     = mul_a * mul_b;
   assign prod_ext = 96'(prod);

   // Accumulate partial products; high halves weigh 2^32
   always_comb begin
      acc_in = acc_ff;
      case (cmd.op)
         ddo_pkg::OP_DIST_A, ddo_pkg::OP_DIST_B, ddo_pkg::OP_X_LO,
         ddo_pkg::OP_Y_LO, ddo_pkg::OP_H_LO: acc_in = prod_ext;
         ddo_pkg::OP_X_HI, ddo_pkg::OP_Y_HI, ddo_pkg::OP_H_HI:
            acc_in = acc_ff + {prod_ext[63:0], 32'b0};
         default: acc_in = acc_ff;
      endcase
   end

   // Centre distance and wheel difference
   assign da_sat_acc = sat62(acc_ff);
   assign db_sat     = da_sat_acc;
   assign sum_ab     = 65'(da_ff) + 65'(db_sat);

   // Fold the heading into the right half-plane
   assign flip = (h_ff[31:30] == 2'd1) || (h_ff[31:30] == 2'd2);
   assign ang  = flip ? (h_ff + 32'h8000_0000) : h_ff;

   assign x_sh     = cx_ff >>> step_ff;
   assign y_sh     = cy_ff >>> step_ff;
   assign atan_ext = 34'(ddo_pkg::atan_lookup(step_ff));

   // Position step and saturating add
   assign step_d  = acc_ff[93:30];
   assign pos_old = (cmd.op == ddo_pkg::OP_X_ADD) ? x_ff : y_ff;
   assign pos_sum = 65'(pos_old) + 65'(step_d);
   always_comb begin
      if (pos_sum > 65'sd2147483647)       pos_new = 32'sh7FFF_FFFF;
      else if (pos_sum < -65'sd2147483648) pos_new = -32'sh8000_0000;
      else                                 pos_new = pos_sum[31:0];
   end

   // Control registers and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= ddo_pkg::CSR_RESET_VAL;
         right_ff  <= ddo_pkg::CSR_RESET_VAL;
         turn_ff   <= ddo_pkg::CSR_RESET_VAL;
         last_a_ff <= '0;
         last_b_ff <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         h_ff      <= '0;
         step_ff   <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               ddo_pkg::CSR_LEFT:  left_ff  <= csr_data;
               ddo_pkg::CSR_RIGHT: right_ff <= csr_data;
               ddo_pkg::CSR_TURN:  turn_ff  <= csr_data;
               default: ;
            endcase
         end
         case (cmd.op)
            ddo_pkg::OP_LOAD: begin
               last_a_ff <= enc_count_a;
               last_b_ff <= enc_count_b;
            end
            ddo_pkg::OP_PREP: step_ff <= '0;
            ddo_pkg::OP_ROT:  step_ff <= step_ff + 5'd1;
            ddo_pkg::OP_X_ADD: x_ff <= pos_new;
            ddo_pkg::OP_Y_ADD: y_ff <= pos_new;
            ddo_pkg::OP_H_ADD: h_ff <= h_ff + acc_ff[2*FRAC_BITS +: 32];
            default: ;
         endcase
      end
   end

   // Working registers of one sample
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      case (cmd.op)
         ddo_pkg::OP_LOAD: begin
            tick_a_ff <= enc_count_a - last_a_ff;
            tick_b_ff <= enc_count_b - last_b_ff;
         end
         ddo_pkg::OP_DIST_B: da_ff <= da_sat_acc;
         ddo_pkg::OP_PREP: begin
            centre_ff <= sum_ab[64:1];
            diff_ff   <= da_ff - db_sat;
            flip_ff   <= flip;
            cx_ff     <= ddo_pkg::CORDIC_X0;
            cy_ff     <= '0;
            cz_ff     <= 34'(signed'(ang));
         end
         ddo_pkg::OP_ROT: begin
            if (!cz_ff[33]) begin
               cx_ff <= cx_ff - y_sh;
               cy_ff <= cy_ff + x_sh;
               cz_ff <= cz_ff - atan_ext;
            end else begin
               cx_ff <= cx_ff + y_sh;
               cy_ff <= cy_ff - x_sh;
               cz_ff <= cz_ff + atan_ext;
            end
         end
         ddo_pkg::OP_FIX: begin
            cos_ff <= flip_ff ? 33'(-cx_ff) : cx_ff[32:0];
            sin_ff <= flip_ff ? 33'(-cy_ff) : cy_ff[32:0];
         end
         default: ;
      endcase
      if (cmd.load_out) begin
         out_x_ff <= x_ff;
         out_y_ff <= y_ff;
         out_h_ff <= h_ff;
      end
   end

   assign pose_x       = out_x_ff;
   assign pose_y       = out_y_ff;
   assign pose_heading = out_h_ff;
endmodule
